FILE: src/mrs_pkg.sv
package mrs_pkg;

	localparam int RX_BYTES_DEF  = 256;
	localparam int TX_BYTES_DEF  = 256;
	localparam int REG_WORDS_DEF = 256;

	localparam logic [7:0]  DEV_ADDR_RST     = 8'h01;
	localparam logic [7:0]  FN_READ_HOLD     = 8'h03;
	localparam logic [7:0]  FN_READ_INPUT    = 8'h04;
	localparam logic [7:0]  FN_WRITE_MULTI   = 8'h10;
	localparam logic [7:0]  FN_SLAVE_ID      = 8'h11;
	localparam logic [7:0]  FN_EXC_FLAG      = 8'h80;
	localparam logic [7:0]  EXC_ILLEGAL_FN   = 8'h01;
	localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
	localparam logic [7:0]  ID_BYTE_COUNT    = 8'h02;
	localparam logic [7:0]  ID_RUN_STATUS    = 8'hFF;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;
	localparam int          READ_MAX_A       = 125;
	localparam int          WRITE_MAX        = 123;
	localparam int          MIN_FRAME        = 4;
	localparam int          HDR_BYTES        = 6;

	typedef enum logic [1:0] {
		OP_RX_BYTE = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_TX_REQ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		HM_EXC1,
		HM_EXC2,
		HM_ID,
		HM_ECHO,
		HM_READ
	} hmode_t;

	typedef enum logic [1:0] {
		FC_READ,
		FC_WRITE,
		FC_ID,
		FC_OTHER
	} fcls_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_HDR,
		S_RD_REQ,
		S_RD_HI,
		S_RD_LO,
		S_WR_REQ,
		S_WR_HI,
		S_WR_LO,
		S_CRC_LO,
		S_CRC_HI,
		S_FINISH,
		S_TX_LOAD
	} state_t;

	typedef struct packed {
		logic   accept;
		logic   dispatch;
		logic   hdr_emit;
		hmode_t hmode;
		logic   rd_req;
		logic   rd_hi;
		logic   rd_lo;
		logic   wr_req;
		logic   wr_hi;
		logic   wr_lo;
		logic   crc_lo;
		logic   crc_hi;
		logic   finish;
		logic   tx_load;
	} cmd_t;

	typedef struct packed {
		logic  frame_go;
		logic  tx_pending;
		fcls_t fcls;
		logic  reply;
		logic  read_bad;
		logic  write_bad;
		logic  hdr_last;
		logic  loop_done;
		logic  out_free;
	} sts_t;

	function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int j = 0; j < 8; j++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

FILE: src/mrs_req_if.sv
interface mrs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  rx_byte;
	logic        frame_end;
	logic [7:0]  update_index;
	logic [15:0] update_value;

	modport source(output valid, func, rx_byte, frame_end, update_index, update_value,
		input ready);
	modport sink(input valid, func, rx_byte, frame_end, update_index, update_value,
		output ready);
endinterface

FILE: src/mrs_rsp_if.sv
interface mrs_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_last;

	modport source(output valid, tx_byte, tx_last, input ready);
	modport sink(input valid, tx_byte, tx_last, output ready);
endinterface

FILE: src/mrs_ctrl.sv
module mrs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_func,
	output logic          in_ready,
	input  mrs_pkg::sts_t sts,
	output mrs_pkg::cmd_t cmd
);

	mrs_pkg::state_t state_q, state_nx;
	mrs_pkg::hmode_t mode_q, mode_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrs_pkg::S_IDLE;
			mode_q  <= mrs_pkg::HM_EXC1;
		end else begin
			state_q <= state_nx;
			mode_q  <= mode_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		mode_nx  = mode_q;
		case (state_q)
			mrs_pkg::S_IDLE: begin
				if (in_valid) begin
					if (in_func == mrs_pkg::OP_RX_BYTE && sts.frame_go)
						state_nx = mrs_pkg::S_DISPATCH;
					else if (in_func == mrs_pkg::OP_TX_REQ && sts.tx_pending)
						state_nx = mrs_pkg::S_TX_LOAD;
				end
			end
			mrs_pkg::S_DISPATCH: begin
				if (sts.fcls == mrs_pkg::FC_WRITE) begin
					if (!sts.write_bad) begin
						state_nx = mrs_pkg::S_WR_REQ;
					end else if (sts.reply) begin
						state_nx = mrs_pkg::S_HDR;
						mode_nx  = mrs_pkg::HM_EXC2;
					end else begin
						state_nx = mrs_pkg::S_IDLE;
					end
				end else if (!sts.reply) begin
					state_nx = mrs_pkg::S_IDLE;
				end else begin
					state_nx = mrs_pkg::S_HDR;
					case (sts.fcls)
						mrs_pkg::FC_READ: mode_nx = sts.read_bad ? mrs_pkg::HM_EXC2 : mrs_pkg::HM_READ;
						mrs_pkg::FC_ID:   mode_nx = mrs_pkg::HM_ID;
						default:          mode_nx = mrs_pkg::HM_EXC1;
					endcase
				end
			end
			mrs_pkg::S_HDR: begin
				if (sts.hdr_last)
					state_nx = (mode_q == mrs_pkg::HM_READ) ? mrs_pkg::S_RD_REQ : mrs_pkg::S_CRC_LO;
			end
			mrs_pkg::S_RD_REQ: state_nx = sts.loop_done ? mrs_pkg::S_CRC_LO : mrs_pkg::S_RD_HI;
			mrs_pkg::S_RD_HI:  state_nx = mrs_pkg::S_RD_LO;
			mrs_pkg::S_RD_LO:  state_nx = mrs_pkg::S_RD_REQ;
			mrs_pkg::S_WR_REQ: begin
				if (!sts.loop_done) begin
					state_nx = mrs_pkg::S_WR_HI;
				end else if (sts.reply) begin
					state_nx = mrs_pkg::S_HDR;
					mode_nx  = mrs_pkg::HM_ECHO;
				end else begin
					state_nx = mrs_pkg::S_IDLE;
				end
			end
			mrs_pkg::S_WR_HI:  state_nx = mrs_pkg::S_WR_LO;
			mrs_pkg::S_WR_LO:  state_nx = mrs_pkg::S_WR_REQ;
			mrs_pkg::S_CRC_LO: state_nx = mrs_pkg::S_CRC_HI;
			mrs_pkg::S_CRC_HI: state_nx = mrs_pkg::S_FINISH;
			mrs_pkg::S_FINISH: state_nx = mrs_pkg::S_IDLE;
			mrs_pkg::S_TX_LOAD: begin
				if (sts.out_free)
					state_nx = mrs_pkg::S_IDLE;
			end
			default: state_nx = mrs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.hmode = mode_q;
		in_ready  = 1'b0;
		case (state_q)
			mrs_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			mrs_pkg::S_DISPATCH: cmd.dispatch = 1'b1;
			mrs_pkg::S_HDR:      cmd.hdr_emit = 1'b1;
			mrs_pkg::S_RD_REQ:   cmd.rd_req   = 1'b1;
			mrs_pkg::S_RD_HI:    cmd.rd_hi    = 1'b1;
			mrs_pkg::S_RD_LO:    cmd.rd_lo    = 1'b1;
			mrs_pkg::S_WR_REQ:   cmd.wr_req   = 1'b1;
			mrs_pkg::S_WR_HI:    cmd.wr_hi    = 1'b1;
			mrs_pkg::S_WR_LO:    cmd.wr_lo    = 1'b1;
			mrs_pkg::S_CRC_LO:   cmd.crc_lo   = 1'b1;
			mrs_pkg::S_CRC_HI:   cmd.crc_hi   = 1'b1;
			mrs_pkg::S_FINISH:   cmd.finish   = 1'b1;
			mrs_pkg::S_TX_LOAD:  cmd.tx_load  = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: src/mrs_datapath.sv
module mrs_datapath #(
	parameter int RX_BYTES  = mrs_pkg::RX_BYTES_DEF,
	parameter int TX_BYTES  = mrs_pkg::TX_BYTES_DEF,
	parameter int REG_WORDS = mrs_pkg::REG_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  logic [1:0]    in_func,
	input  logic [7:0]    in_rx_byte,
	input  logic          in_frame_end,
	input  logic [7:0]    in_update_index,
	input  logic [15:0]   in_update_value,
	input  mrs_pkg::cmd_t cmd,
	output mrs_pkg::sts_t sts,
	mrs_rsp_if.source     rsp
);

	localparam int RX_AW = (RX_BYTES > 1) ? $clog2(RX_BYTES) : 1;
	localparam int TX_AW = (TX_BYTES > 1) ? $clog2(TX_BYTES) : 1;
	localparam int RW_AW = (REG_WORDS > 1) ? $clog2(REG_WORDS) : 1;
	localparam int READ_MAX_B = (TX_BYTES - 5) / 2;
	localparam int READ_MAX = (READ_MAX_B < mrs_pkg::READ_MAX_A) ? READ_MAX_B : mrs_pkg::READ_MAX_A;
	localparam logic [8:0]  RX_LIM   = 9'(RX_BYTES);
	localparam logic [8:0]  RX_OVF   = 9'(RX_BYTES + 1);
	localparam logic [16:0] REG_LIM  = 17'(REG_WORDS);
	localparam logic [15:0] RD_LIM   = 16'(READ_MAX);
	localparam logic [15:0] WR_LIM   = 16'(mrs_pkg::WRITE_MAX);

	logic [7:0]  dev_q;
	logic [7:0]  rx_mem [RX_BYTES];
	logic [7:0]  tx_mem [TX_BYTES];
	logic [15:0] hold_mem [REG_WORDS];
	logic [15:0] inp_mem [REG_WORDS];
	logic [REG_WORDS-1:0] hold_vld_q, inp_vld_q;
	logic [7:0]  h_q [mrs_pkg::HDR_BYTES];
	logic [8:0]  rx_cnt_q, n_q;
	logic [15:0] rx_crc_q, tx_crc_q;
	logic [8:0]  wp_q, tx_len_q, tx_pos_q;
	logic [2:0]  k_q;
	logic [6:0]  i_q;
	logic [15:0] hw_q, iw_q;
	logic        hv_q, iv_q;
	logic [7:0]  rxd_q, hi_q, txd_q;
	logic        rxv_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q, out_valid_q;

	logic        acc_rx, acc_upd, acc_tx;
	logic [15:0] crc_nx;
	logic        fits;
	logic [8:0]  cnt_nx;
	logic [7:0]  fb [mrs_pkg::HDR_BYTES];
	logic [7:0]  fn;
	logic [15:0] start, count;
	logic [16:0] span, wa;
	logic [8:0]  ri;
	logic [2:0]  hdr_len;
	logic [7:0]  hdr_byte, emit_byte, lo_byte;
	logic        emit_en, crc_en, is_input;
	logic [15:0] word;

	assign acc_rx  = cmd.accept && in_func == mrs_pkg::OP_RX_BYTE;
	assign acc_upd = cmd.accept && in_func == mrs_pkg::OP_UPDATE;
	assign acc_tx  = cmd.accept && in_func == mrs_pkg::OP_TX_REQ;

	assign crc_nx = mrs_pkg::crc_update(rx_crc_q, in_rx_byte);
	assign fits   = rx_cnt_q < RX_LIM;
	assign cnt_nx = fits ? rx_cnt_q + 9'd1 : RX_OVF;

	always_comb begin
		for (int j = 0; j < mrs_pkg::HDR_BYTES; j++)
			fb[j] = (9'(j) < n_q) ? h_q[j] : 8'h00;
	end

	assign fn       = fb[1];
	assign start    = {fb[2], fb[3]};
	assign count    = {fb[4], fb[5]};
	assign span     = {1'b0, start} + {1'b0, count};
	assign wa       = {1'b0, start} + 17'(i_q);
	assign ri       = (cmd.wr_hi ? 9'd8 : 9'd7) + {1'b0, i_q, 1'b0};
	assign is_input = fn == mrs_pkg::FN_READ_INPUT;
	assign word     = is_input ? (iv_q ? iw_q : 16'h0000) : (hv_q ? hw_q : 16'h0000);
	assign lo_byte  = rxv_q ? rxd_q : 8'h00;

	always_comb begin
		hdr_len  = 3'd3;
		hdr_byte = dev_q;
		case (cmd.hmode)
			mrs_pkg::HM_EXC1, mrs_pkg::HM_EXC2: begin
				case (k_q)
					3'd0:    hdr_byte = dev_q;
					3'd1:    hdr_byte = fn | mrs_pkg::FN_EXC_FLAG;
					default: hdr_byte = (cmd.hmode == mrs_pkg::HM_EXC1) ?
						mrs_pkg::EXC_ILLEGAL_FN : mrs_pkg::EXC_ILLEGAL_ADDR;
				endcase
			end
			mrs_pkg::HM_ID: begin
				hdr_len = 3'd5;
				case (k_q)
					3'd0:    hdr_byte = dev_q;
					3'd1:    hdr_byte = mrs_pkg::FN_SLAVE_ID;
					3'd2:    hdr_byte = mrs_pkg::ID_BYTE_COUNT;
					3'd3:    hdr_byte = dev_q;
					default: hdr_byte = mrs_pkg::ID_RUN_STATUS;
				endcase
			end
			mrs_pkg::HM_ECHO: begin
				hdr_len = 3'd6;
				case (k_q)
					3'd0:    hdr_byte = fb[0];
					3'd1:    hdr_byte = fb[1];
					3'd2:    hdr_byte = fb[2];
					3'd3:    hdr_byte = fb[3];
					3'd4:    hdr_byte = fb[4];
					default: hdr_byte = fb[5];
				endcase
			end
			mrs_pkg::HM_READ: begin
				case (k_q)
					3'd0:    hdr_byte = dev_q;
					3'd1:    hdr_byte = fn;
					default: hdr_byte = {count[6:0], 1'b0};
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		emit_en   = cmd.hdr_emit | cmd.rd_hi | cmd.rd_lo | cmd.crc_lo | cmd.crc_hi;
		crc_en    = cmd.hdr_emit | cmd.rd_hi | cmd.rd_lo;
		emit_byte = hdr_byte;
		if (cmd.rd_hi)
			emit_byte = word[15:8];
		else if (cmd.rd_lo)
			emit_byte = word[7:0];
		else if (cmd.crc_lo)
			emit_byte = tx_crc_q[7:0];
		else if (cmd.crc_hi)
			emit_byte = tx_crc_q[15:8];
	end

	always_comb begin
		sts.frame_go = in_frame_end && cnt_nx >= 9'(mrs_pkg::MIN_FRAME) && cnt_nx <= RX_LIM &&
			crc_nx == 16'h0000 && (h_q[0] == dev_q || h_q[0] == 8'h00);
		sts.tx_pending = tx_pos_q < tx_len_q;
		case (fn)
			mrs_pkg::FN_READ_HOLD, mrs_pkg::FN_READ_INPUT: sts.fcls = mrs_pkg::FC_READ;
			mrs_pkg::FN_WRITE_MULTI:                       sts.fcls = mrs_pkg::FC_WRITE;
			mrs_pkg::FN_SLAVE_ID:                          sts.fcls = mrs_pkg::FC_ID;
			default:                                       sts.fcls = mrs_pkg::FC_OTHER;
		endcase
		sts.reply     = fb[0] != 8'h00 && fb[0] == dev_q;
		sts.read_bad  = count > RD_LIM || span > REG_LIM;
		sts.write_bad = count > WR_LIM;
		sts.hdr_last  = k_q == hdr_len - 3'd1;
		sts.loop_done = i_q == count[6:0];
		sts.out_free  = !out_valid_q || rsp.ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q       <= mrs_pkg::DEV_ADDR_RST;
			rx_cnt_q    <= '0;
			rx_crc_q    <= mrs_pkg::CRC_INIT;
			n_q         <= '0;
			tx_len_q    <= '0;
			tx_pos_q    <= '0;
			wp_q        <= '0;
			k_q         <= '0;
			i_q         <= '0;
			tx_crc_q    <= mrs_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
			hold_vld_q  <= '0;
			inp_vld_q   <= '0;
		end else begin
			if (cfg_we)
				dev_q <= cfg_wdata;
			if (acc_rx) begin
				if (in_frame_end) begin
					rx_cnt_q <= '0;
					rx_crc_q <= mrs_pkg::CRC_INIT;
					n_q      <= cnt_nx;
				end else begin
					rx_cnt_q <= cnt_nx;
					rx_crc_q <= crc_nx;
				end
			end
			if (acc_upd && {1'b0, in_update_index} < 9'(REG_WORDS))
				inp_vld_q[in_update_index[RW_AW-1:0]] <= 1'b1;
			if (cmd.wr_lo && wa < REG_LIM)
				hold_vld_q[wa[RW_AW-1:0]] <= 1'b1;
			if (cmd.dispatch) begin
				wp_q     <= '0;
				k_q      <= '0;
				i_q      <= '0;
				tx_crc_q <= mrs_pkg::CRC_INIT;
			end
			if (cmd.hdr_emit)
				k_q <= k_q + 3'd1;
			if (cmd.rd_lo || cmd.wr_lo)
				i_q <= i_q + 7'd1;
			if (emit_en)
				wp_q <= wp_q + 9'd1;
			if (crc_en)
				tx_crc_q <= mrs_pkg::crc_update(tx_crc_q, emit_byte);
			if (cmd.finish) begin
				tx_len_q <= wp_q;
				tx_pos_q <= '0;
			end
			if (cmd.tx_load) begin
				out_valid_q <= 1'b1;
				if (tx_pos_q + 9'd1 >= tx_len_q) begin
					tx_pos_q <= '0;
					tx_len_q <= '0;
				end else begin
					tx_pos_q <= tx_pos_q + 9'd1;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers and stores
	always_ff @(posedge clk) begin
		if (acc_rx && rx_cnt_q < 9'(mrs_pkg::HDR_BYTES))
			h_q[rx_cnt_q[2:0]] <= in_rx_byte;
		if (cmd.wr_hi)
			hi_q <= lo_byte;
		if (cmd.tx_load) begin
			out_byte_q <= txd_q;
			out_last_q <= tx_pos_q + 9'd1 >= tx_len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_rx && fits)
			rx_mem[rx_cnt_q[RX_AW-1:0]] <= in_rx_byte;
		if (cmd.wr_req || cmd.wr_hi) begin
			rxd_q <= rx_mem[ri[RX_AW-1:0]];
			rxv_q <= ri < n_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en)
			tx_mem[wp_q[TX_AW-1:0]] <= emit_byte;
		if (acc_tx)
			txd_q <= tx_mem[tx_pos_q[TX_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_lo && wa < REG_LIM)
			hold_mem[wa[RW_AW-1:0]] <= {hi_q, lo_byte};
		if (cmd.rd_req) begin
			hw_q <= hold_mem[wa[RW_AW-1:0]];
			hv_q <= hold_vld_q[wa[RW_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_upd && {1'b0, in_update_index} < 9'(REG_WORDS))
			inp_mem[in_update_index[RW_AW-1:0]] <= in_update_value;
		if (cmd.rd_req) begin
			iw_q <= inp_mem[wa[RW_AW-1:0]];
			iv_q <= inp_vld_q[wa[RW_AW-1:0]];
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.tx_byte = out_byte_q;
	assign rsp.tx_last = out_last_q;

endmodule

FILE: src/modbus_rtu_register_slave.sv
// channel  dir  signals                                                  moves
// req      in   valid ready func rx_byte frame_end update_index/value     one request
// rsp      out  valid ready tx_byte tx_last                               one response byte
// cfg      in   cfg_we cfg_wdata                                          device address
//
// a received byte that does not end a frame, or a register update, leaves the sequencer idle
// a valid frame end walks the request in the sequencer: a read sends the header,
// each word and the crc; a write stores each word, then echoes header and crc
// a transmit request reads the store into a register (registered store read), then waits for rsp space
// reset clears counters, crc, pending response and the register valid bits
module modbus_rtu_register_slave #(
	parameter int RX_BYTES  = mrs_pkg::RX_BYTES_DEF,
	parameter int TX_BYTES  = mrs_pkg::TX_BYTES_DEF,
	parameter int REG_WORDS = mrs_pkg::REG_WORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	mrs_req_if.sink    req,
	mrs_rsp_if.source  rsp
);

	mrs_pkg::cmd_t cmd;
	mrs_pkg::sts_t sts;

	mrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mrs_datapath #(
		.RX_BYTES  (RX_BYTES),
		.TX_BYTES  (TX_BYTES),
		.REG_WORDS (REG_WORDS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_func         (req.func),
		.in_rx_byte      (req.rx_byte),
		.in_frame_end    (req.frame_end),
		.in_update_index (req.update_index),
		.in_update_value (req.update_value),
		.cmd             (cmd),
		.sts             (sts),
		.rsp             (rsp)
	);

endmodule
